/* rtl/core/bfdc_pkg.sv */
// bfdc_pkg: types and fixed constants of the batch flow dispense controller
// used by batch_flow_dispense_controller and its testbench; no dependencies
package bfdc_pkg;

  localparam int unsigned EDGEW  = 4;
  localparam int unsigned PULSEW = 8;
  localparam int unsigned KW     = 20;
  localparam int unsigned VOLCW  = 20;
  localparam int unsigned OVW    = 16;
  localparam int unsigned DLYW   = 16;
  localparam int unsigned VOLW   = 48;
  localparam int unsigned FRACW  = 16;
  localparam int unsigned OUTW   = 32;
  localparam int unsigned CFGIW  = 3;
  localparam int unsigned CFGDW  = 20;

  // shared divider: numerator and divisor widths of the volume path
  localparam int unsigned DIV_NW = 39;
  localparam int unsigned DIV_DW = 22;

  // fixed point scale factors
  localparam logic [12:0] INC_MUL  = 13'd5000;
  localparam logic [1:0]  INC_DIV  = 2'd3;
  localparam logic [26:0] FLOW_MUL = 27'd100000000;
  localparam logic [3:0]  OVR_MUL  = 4'd10;

  // register defaults
  localparam logic [KW-1:0]    K_FACTOR_RST  = 20'd50000;
  localparam logic [VOLCW-1:0] SETPOINT_RST  = 20'd100000;
  localparam logic [VOLCW-1:0] PREACT_RST    = 20'd800;
  localparam logic [OVW-1:0]   OVERRUN_RST   = 16'd10;
  localparam logic [DLYW-1:0]  OPEN_DLY_RST  = 16'd200;
  localparam logic [DLYW-1:0]  CLOSE_DLY_RST = 16'd200;

  typedef enum logic [CFGIW-1:0] {
    REG_K_FACTOR  = 3'd0,
    REG_SETPOINT  = 3'd1,
    REG_PREACT    = 3'd2,
    REG_OVERRUN   = 3'd3,
    REG_OPEN_DLY  = 3'd4,
    REG_CLOSE_DLY = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_DIV_BASE,
    S_DIV_OVR,
    S_CTRL
  } state_t;

  typedef struct packed {
    logic running;
    logic stop_req;
    logic main_open;
    logic fine_open;
    logic counting;
    logic open_pend;
    logic close_pend;
    logic done;
  } flags_t;

endpackage

/* rtl/core/bfdc_div.sv */
// bfdc_div: restoring divider, one quotient bit per cycle
// uses no package items; instantiated by batch_flow_dispense_controller
module bfdc_div #(
  parameter int unsigned NW = 39,
  parameter int unsigned DW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = ~diff[DW];
    rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], qbit};
      rem <= rem_next;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("partial remainder not below divisor");

endmodule

/* rtl/core/batch_flow_dispense_controller.sv */
// batch_flow_dispense_controller: one request per millisecond tick; the result passes through
// S_ACCUM and S_CTRL, at a window end also S_DIV_BASE, and S_DIV_OVR when overrun scaling applies,
// which wait for the 39-step bit-serial dividers (one quotient bit per cycle)
// next request taken the cycle after the result is loaded, S_CTRL waiting while the previous
// result is held by out_stall
// rst is synchronous: registers return to defaults, all flags and counters clear; uses bfdc_pkg, bfdc_div
module batch_flow_dispense_controller #(
  parameter int unsigned WINDOW_TICKS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfdc_pkg::CFGIW-1:0]        cfg_index,
  input  logic [bfdc_pkg::CFGDW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bfdc_pkg::EDGEW-1:0]        edges,
  input  logic                              button_press,
  input  logic                              auto_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              main_valve,
  output logic                              fine_valve,
  output logic                              batch_running,
  output logic                              batch_done,
  output logic [bfdc_pkg::OUTW-1:0]         volume_ml,
  output logic [bfdc_pkg::OUTW-1:0]         flow_ml_per_min
);

  localparam int unsigned TW  = $clog2(WINDOW_TICKS + 1);
  localparam int unsigned FDW = bfdc_pkg::KW + TW;
  localparam int unsigned NW  = bfdc_pkg::DIV_NW;
  localparam int unsigned VW  = bfdc_pkg::VOLW;

  // configuration registers
  logic [bfdc_pkg::KW-1:0]    k_factor;
  logic [bfdc_pkg::VOLCW-1:0] setpoint;
  logic [bfdc_pkg::VOLCW-1:0] preact;
  logic [bfdc_pkg::OVW-1:0]   overrun;
  logic [bfdc_pkg::DLYW-1:0]  open_dly;
  logic [bfdc_pkg::DLYW-1:0]  close_dly;

  bfdc_pkg::state_t state, state_next;
  bfdc_pkg::flags_t flags, flags_next;

  logic [bfdc_pkg::EDGEW-1:0]  edges_q;
  logic                        press_q;
  logic                        auto_q;
  logic [TW-1:0]               tick_cnt;
  logic [TW-1:0]               tick_inc;
  logic                        win_end;
  logic [bfdc_pkg::PULSEW-1:0] pulses;
  logic [bfdc_pkg::PULSEW:0]   pulse_sum;
  logic [bfdc_pkg::PULSEW-1:0] pulses_new;
  logic [VW-1:0]               volume_acc;
  logic [bfdc_pkg::OUTW-1:0]   flow_rate;
  logic [bfdc_pkg::DLYW-1:0]   open_timer, open_timer_next;
  logic [bfdc_pkg::DLYW-1:0]   close_timer, close_timer_next;

  logic                        out_free;
  logic                        commit;
  logic                        vol_clear;

  // divider operands
  logic [bfdc_pkg::KW-1:0]     k_eff;
  logic [bfdc_pkg::OVW-1:0]    ov_eff;
  logic [20:0]                 p_inc;
  logic [NW-1:0]               num_inc;
  logic [NW-1:0]               num_flow;
  logic [NW-1:0]               num_ovr;
  logic [bfdc_pkg::DIV_DW-1:0] den_inc;
  logic [FDW-1:0]              den_flow;
  logic [NW-1:0]               num_a;
  logic [bfdc_pkg::DIV_DW-1:0] den_a;
  logic                        div_a_start, div_a_busy, div_a_done;
  logic                        div_f_start, div_f_busy, div_f_done;
  logic [NW-1:0]               quo_a, quo_f;

  logic signed [20:0]          thr;
  logic                        reached;
  logic                        auto_stop;
  logic [VW:0]                 vol_sum;
  logic [VW-1:0]               vol_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_factor  <= bfdc_pkg::K_FACTOR_RST;
      setpoint  <= bfdc_pkg::SETPOINT_RST;
      preact    <= bfdc_pkg::PREACT_RST;
      overrun   <= bfdc_pkg::OVERRUN_RST;
      open_dly  <= bfdc_pkg::OPEN_DLY_RST;
      close_dly <= bfdc_pkg::CLOSE_DLY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfdc_pkg::REG_K_FACTOR:  k_factor  <= cfg_data[bfdc_pkg::KW-1:0];
        bfdc_pkg::REG_SETPOINT:  setpoint  <= cfg_data[bfdc_pkg::VOLCW-1:0];
        bfdc_pkg::REG_PREACT:    preact    <= cfg_data[bfdc_pkg::VOLCW-1:0];
        bfdc_pkg::REG_OVERRUN:   overrun   <= cfg_data[bfdc_pkg::OVW-1:0];
        bfdc_pkg::REG_OPEN_DLY:  open_dly  <= cfg_data[bfdc_pkg::DLYW-1:0];
        bfdc_pkg::REG_CLOSE_DLY: close_dly <= cfg_data[bfdc_pkg::DLYW-1:0];
        default: ;
      endcase
    end
  end

  // window and operand arithmetic
  always_comb begin
    pulse_sum  = {1'b0, pulses} + (bfdc_pkg::PULSEW + 1)'(edges_q);
    pulses_new = pulses;
    if (flags.counting) begin
      pulses_new = pulse_sum[bfdc_pkg::PULSEW] ? '1 : pulse_sum[bfdc_pkg::PULSEW-1:0];
    end
    tick_inc = tick_cnt + TW'(1);
    win_end  = tick_inc >= TW'(WINDOW_TICKS);

    k_eff    = (k_factor == '0) ? bfdc_pkg::KW'(1) : k_factor;
    ov_eff   = (overrun == '0) ? bfdc_pkg::OVW'(1) : overrun;
    p_inc    = 21'(pulses_new) * 21'(bfdc_pkg::INC_MUL);
    num_inc  = {2'b0, p_inc, {bfdc_pkg::FRACW{1'b0}}};
    num_flow = NW'(35'(pulses_new) * 35'(bfdc_pkg::FLOW_MUL));
    num_ovr  = NW'(quo_a[34:0]) * NW'(bfdc_pkg::OVR_MUL);
    den_inc  = bfdc_pkg::DIV_DW'(k_eff) * bfdc_pkg::DIV_DW'(bfdc_pkg::INC_DIV);
    den_flow = FDW'(k_eff) * FDW'(WINDOW_TICKS);
    num_a    = (state == bfdc_pkg::S_ACCUM) ? num_inc : num_ovr;
    den_a    = (state == bfdc_pkg::S_ACCUM) ? den_inc : bfdc_pkg::DIV_DW'(ov_eff);

    thr       = $signed({1'b0, setpoint}) - $signed({1'b0, preact});
    reached   = (thr <= 21'sd0) ||
                (volume_acc >= {12'b0, thr[19:0], {bfdc_pkg::FRACW{1'b0}}});
    auto_stop = flags.main_open && auto_q && reached;

    vol_sum = {1'b0, volume_acc} + (VW + 1)'(quo_a);
    vol_sat = vol_sum[VW] ? '1 : vol_sum[VW-1:0];
  end

  bfdc_div #(
    .NW (NW),
    .DW (bfdc_pkg::DIV_DW)
  ) u_div_vol (
    .clk   (clk),
    .rst   (rst),
    .start (div_a_start),
    .num   (num_a),
    .den   (den_a),
    .busy  (div_a_busy),
    .done  (div_a_done),
    .quo   (quo_a)
  );

  bfdc_div #(
    .NW (NW),
    .DW (FDW)
  ) u_div_flow (
    .clk   (clk),
    .rst   (rst),
    .start (div_f_start),
    .num   (num_flow),
    .den   (den_flow),
    .busy  (div_f_busy),
    .done  (div_f_done),
    .quo   (quo_f)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfdc_pkg::S_IDLE:     if (in_valid) state_next = bfdc_pkg::S_ACCUM;
      bfdc_pkg::S_ACCUM:    state_next = win_end ? bfdc_pkg::S_DIV_BASE : bfdc_pkg::S_CTRL;
      bfdc_pkg::S_DIV_BASE: begin
        if (div_a_done) state_next = auto_stop ? bfdc_pkg::S_DIV_OVR : bfdc_pkg::S_CTRL;
      end
      bfdc_pkg::S_DIV_OVR:  if (div_a_done) state_next = bfdc_pkg::S_CTRL;
      bfdc_pkg::S_CTRL:     if (out_free) state_next = bfdc_pkg::S_IDLE;
      default:              state_next = bfdc_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall    = (state != bfdc_pkg::S_IDLE);
    out_free    = !out_valid || !out_stall;
    commit      = (state == bfdc_pkg::S_CTRL) && out_free;
    div_f_start = (state == bfdc_pkg::S_ACCUM) && win_end;
    div_a_start = div_f_start ||
                  ((state == bfdc_pkg::S_DIV_BASE) && div_a_done && auto_stop);
  end

  // press, stop request and valve delays
  always_comb begin
    logic act;
    logic check;
    flags_next       = flags;
    open_timer_next  = open_timer;
    close_timer_next = close_timer;
    vol_clear        = 1'b0;
    act              = 1'b1;
    check            = 1'b1;
    if (press_q || flags.stop_req) begin
      if (flags.stop_req) begin
        flags_next.stop_req = 1'b0;
      end else if (auto_q && flags.running) begin
        act   = 1'b0;
        check = 1'b0;
      end else begin
        flags_next.running = !flags.running;
      end
      if (act) begin
        if (flags_next.running && !flags.main_open) begin
          flags_next.open_pend = 1'b1;
          flags_next.main_open = 1'b1;
          open_timer_next      = '0;
          vol_clear            = 1'b1;
        end else begin
          flags_next.close_pend = 1'b1;
          flags_next.fine_open  = 1'b0;
          close_timer_next      = '0;
        end
      end
    end
    if (check) begin
      if (flags_next.open_pend && open_timer_next >= open_dly) begin
        flags_next.open_pend = 1'b0;
        flags_next.fine_open = 1'b1;
        flags_next.counting  = 1'b1;
      end
      if (flags_next.close_pend && close_timer_next >= close_dly) begin
        flags_next.close_pend = 1'b0;
        flags_next.main_open  = 1'b0;
        flags_next.counting   = 1'b0;
        flags_next.done       = 1'b1;
      end
    end
    if (flags_next.open_pend && open_timer_next != '1) begin
      open_timer_next = open_timer_next + bfdc_pkg::DLYW'(1);
    end
    if (flags_next.close_pend && close_timer_next != '1) begin
      close_timer_next = close_timer_next + bfdc_pkg::DLYW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bfdc_pkg::S_IDLE;
      flags       <= '0;
      tick_cnt    <= '0;
      pulses      <= '0;
      volume_acc  <= '0;
      flow_rate   <= '0;
      open_timer  <= '0;
      close_timer <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bfdc_pkg::S_ACCUM: begin
          if (win_end) begin
            tick_cnt <= '0;
            pulses   <= '0;
          end else begin
            tick_cnt <= tick_inc;
            pulses   <= pulses_new;
          end
        end
        bfdc_pkg::S_DIV_BASE: begin
          if (div_a_done) begin
            flow_rate <= (quo_f[NW-1:bfdc_pkg::OUTW] != '0) ? '1 : quo_f[bfdc_pkg::OUTW-1:0];
            if (auto_stop) begin
              if (flags.running) begin
                flags.running  <= 1'b0;
                flags.stop_req <= 1'b1;
                volume_acc     <= vol_sat;
              end
            end else begin
              volume_acc <= vol_sat;
            end
          end
        end
        bfdc_pkg::S_DIV_OVR: begin
          if (div_a_done) volume_acc <= vol_sat;
        end
        bfdc_pkg::S_CTRL: begin
          if (commit) begin
            flags       <= flags_next;
            open_timer  <= open_timer_next;
            close_timer <= close_timer_next;
            if (vol_clear) volume_acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == bfdc_pkg::S_IDLE && in_valid) begin
      edges_q <= edges;
      press_q <= button_press;
      auto_q  <= auto_mode;
    end
    if (commit) begin
      main_valve      <= flags_next.main_open;
      fine_valve      <= flags_next.fine_open;
      batch_running   <= flags_next.running;
      batch_done      <= flags_next.done;
      volume_ml       <= vol_clear ? '0 : volume_acc[bfdc_pkg::FRACW +: bfdc_pkg::OUTW];
      flow_ml_per_min <= flow_rate;
    end
  end

  a_div_pair: assert property (@(posedge clk) disable iff (rst)
      (state == bfdc_pkg::S_DIV_BASE && div_a_done) |-> div_f_done)
    else $error("flow and volume divisions out of step");
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
      tick_cnt < TW'(WINDOW_TICKS))
    else $error("window tick counter out of range");
  a_load_from_ctrl: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == bfdc_pkg::S_CTRL))
    else $error("result loaded outside the control step");
  a_stop_consumed: assert property (@(posedge clk) disable iff (rst)
      (state == bfdc_pkg::S_IDLE) |-> !flags.stop_req)
    else $error("stop request left pending between requests");
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
      (state == bfdc_pkg::S_IDLE || state == bfdc_pkg::S_CTRL) |-> !div_a_busy && !div_f_busy)
    else $error("divider busy outside the division steps");

endmodule

/* tb/tb_batch_flow_dispense_controller.sv */
// tb_batch_flow_dispense_controller: self-checking bench for the batch dispense controller,
// predicting valves, flags, volume and flow for every millisecond tick request
// depends on bfdc_pkg and batch_flow_dispense_controller
module tb_batch_flow_dispense_controller;

  localparam int unsigned WINDOW_TICKS = 10;
  localparam int unsigned HANG_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned GROW_TICKS   = 200;
  localparam int unsigned RANDOM_TICKS = 1300;
  localparam int unsigned PHASE_TICKS  = 300;
  localparam int unsigned MAX_REPORTS  = 200;

  localparam logic [bfdc_pkg::CFGIW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bfdc_pkg::CFGIW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [bfdc_pkg::VOLW-1:0]  VOL_FULL     = '1;

  typedef struct packed {
    logic                      main_valve;
    logic                      fine_valve;
    logic                      batch_running;
    logic                      batch_done;
    logic [bfdc_pkg::OUTW-1:0] volume_ml;
    logic [bfdc_pkg::OUTW-1:0] flow_ml_per_min;
  } tick_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [bfdc_pkg::CFGIW-1:0] cfg_index = '0;
  logic [bfdc_pkg::CFGDW-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [bfdc_pkg::EDGEW-1:0] edges = '0;
  logic                       button_press = 1'b0;
  logic                       auto_mode = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       main_valve;
  logic                       fine_valve;
  logic                       batch_running;
  logic                       batch_done;
  logic [bfdc_pkg::OUTW-1:0]  volume_ml;
  logic [bfdc_pkg::OUTW-1:0]  flow_ml_per_min;

  batch_flow_dispense_controller #(.WINDOW_TICKS(WINDOW_TICKS)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .edges          (edges),
    .button_press   (button_press),
    .auto_mode      (auto_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .main_valve     (main_valve),
    .fine_valve     (fine_valve),
    .batch_running  (batch_running),
    .batch_done     (batch_done),
    .volume_ml      (volume_ml),
    .flow_ml_per_min(flow_ml_per_min)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predicted controller registers and state
  bit [bfdc_pkg::KW-1:0]     k_cfg;
  bit [bfdc_pkg::VOLCW-1:0]  setpoint_cfg;
  bit [bfdc_pkg::VOLCW-1:0]  preact_cfg;
  bit [bfdc_pkg::OVW-1:0]    overrun_cfg;
  bit [bfdc_pkg::DLYW-1:0]   open_dly_cfg;
  bit [bfdc_pkg::DLYW-1:0]   close_dly_cfg;
  int unsigned               win_ticks;
  bit [bfdc_pkg::PULSEW-1:0] win_pulses;
  bit [bfdc_pkg::VOLW-1:0]   vol_q16;
  bit [bfdc_pkg::OUTW-1:0]   flow_reg;
  bit                        batch_on;
  bit                        stop_pending;
  bit                        main_is_open;
  bit                        fine_is_open;
  bit                        count_en;
  bit                        open_wait;
  bit                        close_wait;
  bit                        done_latched;
  bit [bfdc_pkg::DLYW-1:0]   open_ticks;
  bit [bfdc_pkg::DLYW-1:0]   close_ticks;

  tick_result_t awaited_ticks[$];
  int unsigned  ticks_sent = 0;
  int unsigned  fail_count = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int unsigned  hold_req = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  stuck_cycles = 0;

  function automatic void add_volume(input longint unsigned inc);
    longint unsigned room;
    room = VOL_FULL - vol_q16;
    if (inc > room) begin
      vol_q16 = VOL_FULL;
    end else begin
      vol_q16 = vol_q16 + inc[bfdc_pkg::VOLW-1:0];
    end
  endfunction

  function automatic void close_window(input bit auto_on);
    longint unsigned k;
    longint unsigned ov;
    longint unsigned inc;
    longint unsigned rate;
    longint unsigned thr_q16;
    bit              reached;
    k = (k_cfg == 0) ? 64'd1 : k_cfg;
    ov = (overrun_cfg == 0) ? 64'd1 : overrun_cfg;
    inc = win_pulses;
    inc = inc * 64'd5000 * 64'd65536 / (64'd3 * k);
    rate = win_pulses;
    rate = rate * 64'd100000000 / (WINDOW_TICKS * k);
    reached = (preact_cfg >= setpoint_cfg);
    if (!reached) begin
      thr_q16 = setpoint_cfg - preact_cfg;
      thr_q16 = thr_q16 << 16;
      reached = (vol_q16 >= thr_q16);
    end
    flow_reg = (rate > 64'hFFFF_FFFF) ? '1 : rate[bfdc_pkg::OUTW-1:0];
    win_pulses = '0;
    if (main_is_open && auto_on && reached) begin
      if (batch_on) begin
        batch_on = 1'b0;
        stop_pending = 1'b1;
        add_volume(inc);
      end
      add_volume(inc * 64'd10 / ov);
    end else begin
      add_volume(inc);
    end
  endfunction

  function automatic tick_result_t predict_tick_result(input bit [bfdc_pkg::EDGEW-1:0] e,
                                                       input bit press, input bit auto_on);
    tick_result_t r;
    bit           act;
    bit           gate_delays;
    int unsigned  sum;
    gate_delays = 1'b1;
    if (count_en) begin
      sum = win_pulses + e;
      win_pulses = (sum > 255) ? 8'd255 : sum[bfdc_pkg::PULSEW-1:0];
    end
    win_ticks++;
    if (win_ticks >= WINDOW_TICKS) begin
      win_ticks = 0;
      close_window(auto_on);
    end
    if (press || stop_pending) begin
      act = 1'b1;
      if (stop_pending) begin
        stop_pending = 1'b0;
      end else if (auto_on && batch_on) begin
        act = 1'b0;
        gate_delays = 1'b0;
      end else begin
        batch_on = !batch_on;
      end
      if (act) begin
        if (batch_on && !main_is_open) begin
          open_wait = 1'b1;
          open_ticks = '0;
          main_is_open = 1'b1;
          vol_q16 = '0;
        end else begin
          close_wait = 1'b1;
          close_ticks = '0;
          fine_is_open = 1'b0;
        end
      end
    end
    if (gate_delays) begin
      if (open_wait && open_ticks >= open_dly_cfg) begin
        open_wait = 1'b0;
        fine_is_open = 1'b1;
        count_en = 1'b1;
      end
      if (close_wait && close_ticks >= close_dly_cfg) begin
        close_wait = 1'b0;
        main_is_open = 1'b0;
        count_en = 1'b0;
        done_latched = 1'b1;
      end
    end
    if (open_wait && open_ticks != '1) open_ticks++;
    if (close_wait && close_ticks != '1) close_ticks++;
    r.main_valve = main_is_open;
    r.fine_valve = fine_is_open;
    r.batch_running = batch_on;
    r.batch_done = done_latched;
    r.volume_ml = vol_q16[bfdc_pkg::VOLW-1:bfdc_pkg::FRACW];
    r.flow_ml_per_min = flow_reg;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [bfdc_pkg::OUTW-1:0] want,
                             input logic [bfdc_pkg::OUTW-1:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_ticks.size() == 0) begin
        if (fail_count < MAX_REPORTS) $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = awaited_ticks.pop_front();
        check_field("main_valve", want.main_valve, main_valve);
        check_field("fine_valve", want.fine_valve, fine_valve);
        check_field("batch_running", want.batch_running, batch_running);
        check_field("batch_done", want.batch_done, batch_done);
        check_field("volume_ml", want.volume_ml, volume_ml);
        check_field("flow_ml_per_min", want.flow_ml_per_min, flow_ml_per_min);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= HANG_LIMIT) begin
      $display("batch_flow_dispense_controller test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_tick(input bit [bfdc_pkg::EDGEW-1:0] e, input bit press,
                           input bit auto_on);
    while (tx_idle_en && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    edges <= e;
    button_press <= press;
    auto_mode <= auto_on;
    do @(posedge clk); while (in_stall);
    awaited_ticks.push_back(predict_tick_result(e, press, auto_on));
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bfdc_pkg::CFGIW-1:0] idx,
                           input logic [bfdc_pkg::CFGDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bfdc_pkg::REG_K_FACTOR:  k_cfg = val[bfdc_pkg::KW-1:0];
      bfdc_pkg::REG_SETPOINT:  setpoint_cfg = val[bfdc_pkg::VOLCW-1:0];
      bfdc_pkg::REG_PREACT:    preact_cfg = val[bfdc_pkg::VOLCW-1:0];
      bfdc_pkg::REG_OVERRUN:   overrun_cfg = val[bfdc_pkg::OVW-1:0];
      bfdc_pkg::REG_OPEN_DLY:  open_dly_cfg = val[bfdc_pkg::DLYW-1:0];
      bfdc_pkg::REG_CLOSE_DLY: close_dly_cfg = val[bfdc_pkg::DLYW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input bit [bfdc_pkg::KW-1:0] k, input bit [bfdc_pkg::VOLCW-1:0] sp,
                            input bit [bfdc_pkg::VOLCW-1:0] pa,
                            input bit [bfdc_pkg::CFGDW-1:0] ov,
                            input bit [bfdc_pkg::CFGDW-1:0] od,
                            input bit [bfdc_pkg::CFGDW-1:0] cd);
    drain_results();
    write_reg(bfdc_pkg::REG_K_FACTOR, k);
    write_reg(bfdc_pkg::REG_SETPOINT, sp);
    write_reg(bfdc_pkg::REG_PREACT, pa);
    write_reg(bfdc_pkg::REG_OVERRUN, ov);
    write_reg(bfdc_pkg::REG_OPEN_DLY, od);
    write_reg(bfdc_pkg::REG_CLOSE_DLY, cd);
    cfg_valid <= 1'b0;
  endtask

  // zero k-factor, overrun and delays; auto stop at a window end absorbs a press
  task automatic test_zero_settings();
    set_config(0, 0, 0, 0, 0, 0);
    send_tick(15, 1'b1, 1'b0);
    repeat (8) send_tick(15, 1'b0, 1'b0);
    send_tick(15, 1'b1, 1'b1);
    send_tick(0, 1'b1, 1'b1);
    send_tick(0, 1'b1, 1'b0);
  endtask

  // ignored press in auto, negative threshold, stop during the open delay
  task automatic test_press_handling();
    drain_results();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    set_config('1, 0, '1, '1, 3, 2);
    send_tick(0, 1'b1, 1'b1);
    send_tick(15, 1'b1, 1'b1);
    repeat (6) send_tick(15, 1'b0, 1'b1);
    send_tick(9, 1'b0, 1'b0);
    send_tick(6, 1'b0, 1'b0);
    send_tick(0, 1'b1, 1'b0);
    send_tick(0, 1'b1, 1'b0);
    send_tick(0, 1'b0, 1'b0);
  endtask

  // main valve held open after the auto stop, volume grows by the overrun share
  task automatic test_overrun_growth();
    set_config(0, 0, 0, 0, 0, 16'hFFFF);
    send_tick(0, 1'b1, 1'b0);
    repeat (GROW_TICKS) send_tick(15, 1'b0, 1'b1);
    set_config(0, 0, 0, 0, 0, 0);
    send_tick(0, 1'b0, 1'b0);
  endtask

  task automatic test_output_hold();
    set_config(200, 2000, 100, 10, 5, 5);
    hold_req <= hold_req + 1;
    repeat (40)
      send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), $urandom_range(99) < 10,
                1'($urandom_range(1)));
    drain_results();
  endtask

  task automatic test_no_idle_stretch();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (300)
      send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), $urandom_range(99) < 5,
                1'($urandom_range(1)));
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_random_batches();
    int unsigned               first;
    int unsigned               phase_mark;
    int unsigned               len;
    bit                        auto_run;
    bit [bfdc_pkg::KW-1:0]     k;
    bit [bfdc_pkg::VOLCW-1:0]  sp;
    bit [bfdc_pkg::VOLCW-1:0]  pa;
    bit [bfdc_pkg::OVW-1:0]    ov;
    bit [bfdc_pkg::DLYW-1:0]   od;
    bit [bfdc_pkg::DLYW-1:0]   cd;
    first = ticks_sent;
    phase_mark = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      if (ticks_sent == first || ticks_sent - phase_mark >= PHASE_TICKS) begin
        phase_mark = ticks_sent;
        case ($urandom_range(7))
          0: k = 0;
          1: k = 1;
          2: k = 1000000;
          3: k = '1;
          default: k = bfdc_pkg::KW'($urandom_range(1, 3000));
        endcase
        case ($urandom_range(7))
          0: sp = 0;
          1: sp = 1000000;
          2: sp = '1;
          default: sp = bfdc_pkg::VOLCW'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(7))
          0: pa = 0;
          1: pa = '1;
          default: pa = bfdc_pkg::VOLCW'($urandom_range(0, 400));
        endcase
        case ($urandom_range(5))
          0: ov = 0;
          1: ov = 1;
          2: ov = '1;
          default: ov = bfdc_pkg::OVW'($urandom_range(1, 40));
        endcase
        case ($urandom_range(15))
          0: od = 0;
          1: od = '1;
          default: od = bfdc_pkg::DLYW'($urandom_range(0, 30));
        endcase
        case ($urandom_range(15))
          0: cd = 0;
          1: cd = '1;
          default: cd = bfdc_pkg::DLYW'($urandom_range(0, 30));
        endcase
        set_config(k, sp, pa, {4'($urandom_range(15)), ov}, {4'($urandom_range(15)), od},
                   {4'($urandom_range(15)), cd});
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 20))
          send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else begin
        auto_run = 1'($urandom_range(1));
        send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), 1'b1, auto_run);
        len = $urandom_range(10, 120);
        repeat (len)
          send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), $urandom_range(99) < 3,
                    ($urandom_range(99) < 90) ? auto_run : !auto_run);
        if (!auto_run) send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), 1'b1, 1'b0);
        repeat ($urandom_range(0, 40))
          send_tick(bfdc_pkg::EDGEW'($urandom_range(15)), 1'b0, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    k_cfg = bfdc_pkg::K_FACTOR_RST;
    setpoint_cfg = bfdc_pkg::SETPOINT_RST;
    preact_cfg = bfdc_pkg::PREACT_RST;
    overrun_cfg = bfdc_pkg::OVERRUN_RST;
    open_dly_cfg = bfdc_pkg::OPEN_DLY_RST;
    close_dly_cfg = bfdc_pkg::CLOSE_DLY_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_settings();
    test_press_handling();
    test_overrun_growth();
    test_output_hold();
    test_no_idle_stretch();
    test_random_batches();
    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && awaited_ticks.size() == 0) begin
      $display("batch_flow_dispense_controller test passed");
    end else begin
      $display("batch_flow_dispense_controller test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bfdc_pkg.sv
rtl/core/bfdc_div.sv
rtl/core/batch_flow_dispense_controller.sv
tb/tb_batch_flow_dispense_controller.sv
